// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; the including module provides clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable
`define GBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication, its consequent checked at the next clock
`define GBC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/gbc_pkg.sv -----
// package for the gost block cipher: command and register codes, stage type,
// s-box table and round function; no dependencies
package gbc_pkg;

  localparam int unsigned NumRounds = 32;
  localparam logic [31:0] CtrAddHigh = 32'h0101_0104;
  localparam logic [31:0] CtrAddLow  = 32'h0101_0101;

  typedef enum logic [1:0] {
    CMD_ENCRYPT = 2'd0,
    CMD_DECRYPT = 2'd1,
    CMD_CTR_XOR = 2'd2,
    CMD_RESTART = 2'd3
  } gbc_cmd_e;

  typedef enum logic [2:0] {
    REG_KEY_01 = 3'd0,
    REG_KEY_23 = 3'd1,
    REG_KEY_45 = 3'd2,
    REG_KEY_67 = 3'd3,
    REG_IV     = 3'd4
  } gbc_reg_e;

  typedef logic [7:0][31:0] gbc_key_t;

  typedef struct packed {
    logic        vld;
    gbc_cmd_e    cmd;
    logic [31:0] n1;
    logic [31:0] n2;
    logic [63:0] data;
  } gbc_stage_t;

  localparam logic [0:7][0:15][3:0] SBox = '{
    '{4'h4, 4'hA, 4'h9, 4'h2, 4'hD, 4'h8, 4'h0, 4'hE,
      4'h6, 4'hB, 4'h1, 4'hC, 4'h7, 4'hF, 4'h5, 4'h3},
    '{4'hB, 4'hE, 4'h4, 4'hC, 4'h6, 4'hD, 4'hF, 4'hA,
      4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
    '{4'h5, 4'h8, 4'h1, 4'hD, 4'hA, 4'h3, 4'h4, 4'h2,
      4'hE, 4'hF, 4'hC, 4'h7, 4'h6, 4'h0, 4'h9, 4'hB},
    '{4'h7, 4'hD, 4'hA, 4'h1, 4'h0, 4'h8, 4'h9, 4'hF,
      4'hE, 4'h4, 4'h6, 4'hC, 4'hB, 4'h2, 4'h5, 4'h3},
    '{4'h6, 4'hC, 4'h7, 4'h1, 4'h5, 4'hF, 4'hD, 4'h8,
      4'h4, 4'hA, 4'h9, 4'hE, 4'h0, 4'h3, 4'hB, 4'h2},
    '{4'h4, 4'hB, 4'hA, 4'h0, 4'h7, 4'h2, 4'h1, 4'hD,
      4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hC, 4'hF, 4'hE},
    '{4'hD, 4'hB, 4'h4, 4'h1, 4'h3, 4'hF, 4'h5, 4'h9,
      4'h0, 4'hA, 4'hE, 4'h7, 4'h6, 4'h8, 4'h2, 4'hC},
    '{4'h1, 4'hF, 4'hD, 4'h0, 4'h5, 4'h7, 4'hA, 4'h4,
      4'h9, 4'h2, 4'h3, 4'hE, 4'h6, 4'hB, 4'h8, 4'hC}
  };

  // s-box row r works on nibble 7-r (row 0 on the top nibble), then rotl 11
  function automatic logic [31:0] gbc_round_fn(logic [31:0] x);
    logic [31:0] y;
    y = '0;
    for (int r = 0; r < 8; r++) begin
      y[4*(7-r) +: 4] = SBox[r][x[4*(7-r) +: 4]];
    end
    return {y[20:0], y[31:21]};
  endfunction

endpackage

// ----- design/gost_block_cipher_counter_mode.sv -----
// top level of the gost 28147-89 cipher with ecb and counter commands
// depends on gbc_pkg and gbc_round_cell
//
// usage
// - request channel: in_valid_i / in_stall_o with cmd_i and data_in_i; a
//   request is taken at a rising edge with valid high and stall low
// - result channel: out_valid_o / out_stall_i with data_out_o, one result per
//   request, in request order
// - configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (keys 0-1, 2-3, 4-5, 6-7, then the counter start value); write only
//   while no request is in flight
// - the counter is advanced (or reloaded on restart) as the request is
//   taken, so back-to-back counter requests see successive values
// - from request to result: one round cell per round, 32 cells in a row,
//   plus the output register
// - throughput: one request per cycle unless stalled; the chain is fully pipelined
// - when the receiver stalls, a skid register catches the next result and
//   the chain keeps moving; once the skid is full the chain freezes and
//   in_stall_o goes high
// - reset clears keys, start value, counter and every valid flag
module gost_block_cipher_counter_mode (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] data_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] data_out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int unsigned NR = gbc_pkg::NumRounds;

  // configuration registers
  gbc_pkg::gbc_key_t key_q;
  logic [63:0]       iv_q;

  // keystream counter
  logic [63:0] ctr_q;
  logic [63:0] ctr_d;
  logic [63:0] ctr_next;
  logic [32:0] hi_sum;

  // chain control
  logic                advance;
  logic                in_take;
  gbc_pkg::gbc_cmd_e   cmd;
  gbc_pkg::gbc_stage_t chain [NR+1];

  // result tail
  logic [63:0] result;
  logic [63:0] cipher_out;
  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic        skid_valid_q;
  logic [63:0] skid_data_q;
  logic        out_take;

  assign cmd     = gbc_pkg::gbc_cmd_e'(cmd_i);
  assign advance = !skid_valid_q;
  assign in_take = in_valid_i && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      iv_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbc_pkg::REG_KEY_01: key_q[1:0] <= cfg_wdata_i;
        gbc_pkg::REG_KEY_23: key_q[3:2] <= cfg_wdata_i;
        gbc_pkg::REG_KEY_45: key_q[5:4] <= cfg_wdata_i;
        gbc_pkg::REG_KEY_67: key_q[7:6] <= cfg_wdata_i;
        gbc_pkg::REG_IV:     iv_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // high half adds modulo 2^32-1 (end-around carry), low half modulo 2^32
  always_comb begin
    hi_sum   = {1'b0, ctr_q[63:32]} + {1'b0, gbc_pkg::CtrAddHigh};
    ctr_next = {hi_sum[31:0] + {31'd0, hi_sum[32]}, ctr_q[31:0] + gbc_pkg::CtrAddLow};
    ctr_d    = ctr_q;
    if (in_take) begin
      case (cmd)
        gbc_pkg::CMD_CTR_XOR: ctr_d = ctr_next;
        gbc_pkg::CMD_RESTART: ctr_d = iv_q;
        default:              ctr_d = ctr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else begin
      ctr_q <= ctr_d;
    end
  end

  // head of the chain: counter requests encrypt the advanced counter
  always_comb begin
    chain[0].vld  = in_take;
    chain[0].cmd  = cmd;
    chain[0].data = data_in_i;
    if (cmd == gbc_pkg::CMD_CTR_XOR) begin
      chain[0].n1 = ctr_next[31:0];
      chain[0].n2 = ctr_next[63:32];
    end else begin
      chain[0].n1 = data_in_i[31:0];
      chain[0].n2 = data_in_i[63:32];
    end
  end

  for (genvar i = 0; i < NR; i++) begin : g_cell
    gbc_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .round_i (5'(i)),
      .key_i   (key_q),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // halves swap on output; counter mode xors, restart gives zero
  always_comb begin
    cipher_out = {chain[NR].n1, chain[NR].n2};
    case (chain[NR].cmd)
      gbc_pkg::CMD_CTR_XOR: result = chain[NR].data ^ cipher_out;
      gbc_pkg::CMD_RESTART: result = '0;
      default:              result = cipher_out;
    endcase
  end

  assign out_take = out_valid_q && !out_stall_i;

  // output register with skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= chain[NR].vld;
      end
    end else if (chain[NR].vld && advance) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      out_data_q <= skid_valid_q ? skid_data_q : result;
    end else if (advance) begin
      skid_data_q <= result;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

endmodule

// ----- design/gbc_round_cell.sv -----
// one feistel round cell of the cipher chain
// depends on gbc_pkg
module gbc_round_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [4:0]          round_i,
  input  gbc_pkg::gbc_key_t   key_i,
  input  gbc_pkg::gbc_stage_t stage_i,
  output gbc_pkg::gbc_stage_t stage_o
);

  logic                vld_q;
  gbc_pkg::gbc_stage_t pay_q;
  gbc_pkg::gbc_stage_t pay_d;
  logic                forward;
  logic [2:0]          key_idx;
  logic [31:0]         f_in;
  logic [31:0]         f_out;

  always_comb begin
    if (stage_i.cmd == gbc_pkg::CMD_DECRYPT) begin
      forward = (round_i < 5'd8);
    end else begin
      forward = (round_i < 5'd24);
    end
    key_idx = forward ? round_i[2:0] : ~round_i[2:0];
    f_in    = (round_i[0] ? stage_i.n2 : stage_i.n1) + key_i[key_idx];
    f_out   = gbc_pkg::gbc_round_fn(f_in);
    pay_d   = stage_i;
    if (round_i[0]) begin
      pay_d.n1 = stage_i.n1 ^ f_out;
    end else begin
      pay_d.n2 = stage_i.n2 ^ f_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    stage_o     = pay_q;
    stage_o.vld = vld_q;
  end

endmodule

// ----- design/gbc_checker.sv -----
// port-level checker for the gost cipher top level, with its bind
// depends on assert_macros.svh
`include "assert_macros.svh"

module gbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] data_out_o
);

  // a held result stays put
  `GBC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(data_out_o), "result changed while stalled")
  // request side stalls only behind a full output register
  `GBC_ASSERT(a_stall_needs_out, !in_stall_o || out_valid_o, "request stall without pending result")
  // skid fills only while the result is stalled
  `GBC_ASSERT(a_stall_rise, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i), "skid filled without stall")
  // skid drains only when a result is taken
  `GBC_ASSERT(a_stall_fall, $fell(in_stall_o) |-> $past(out_valid_o && !out_stall_i), "skid drained without take")

endmodule

bind gost_block_cipher_counter_mode gbc_checker u_gbc_checker (.*);

// ----- bench/gost_block_cipher_counter_mode_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for gost_block_cipher_counter_mode: directed table, then random phases
// depends on gbc_pkg for the command and register codes; holds its own cipher predictor
module gost_block_cipher_counter_mode_tb;

  // counter steps, the high one is added modulo 2^32-1
  localparam logic [31:0] StepHigh = 32'h0101_0104;
  localparam logic [31:0] StepLow  = 32'h0101_0101;
  localparam int unsigned NumPhases = 7;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned DrainCycles = 40;   // pipeline is 33 deep, plus slack

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [63:0] data_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] data_out_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  gost_block_cipher_counter_mode uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .data_in_i  (data_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_out_o (data_out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor state: key words, start value and keystream counter as the
  // block should hold them
  // ---------------------------------------------------------------------------
  logic [31:0] key_word [8];
  logic [63:0] iv_value;
  logic [63:0] ctr_value;

  // substitution table, row r acts on the nibble at bits 31-4r..28-4r
  logic [3:0] sub_table [8][16] = '{
    '{4'h4, 4'hA, 4'h9, 4'h2, 4'hD, 4'h8, 4'h0, 4'hE, 4'h6, 4'hB, 4'h1, 4'hC, 4'h7, 4'hF, 4'h5, 4'h3},
    '{4'hB, 4'hE, 4'h4, 4'hC, 4'h6, 4'hD, 4'hF, 4'hA, 4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
    '{4'h5, 4'h8, 4'h1, 4'hD, 4'hA, 4'h3, 4'h4, 4'h2, 4'hE, 4'hF, 4'hC, 4'h7, 4'h6, 4'h0, 4'h9, 4'hB},
    '{4'h7, 4'hD, 4'hA, 4'h1, 4'h0, 4'h8, 4'h9, 4'hF, 4'hE, 4'h4, 4'h6, 4'hC, 4'hB, 4'h2, 4'h5, 4'h3},
    '{4'h6, 4'hC, 4'h7, 4'h1, 4'h5, 4'hF, 4'hD, 4'h8, 4'h4, 4'hA, 4'h9, 4'hE, 4'h0, 4'h3, 4'hB, 4'h2},
    '{4'h4, 4'hB, 4'hA, 4'h0, 4'h7, 4'h2, 4'h1, 4'hD, 4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hC, 4'hF, 4'hE},
    '{4'hD, 4'hB, 4'h4, 4'h1, 4'h3, 4'hF, 4'h5, 4'h9, 4'h0, 4'hA, 4'hE, 4'h7, 4'h6, 4'h8, 4'h2, 4'hC},
    '{4'h1, 4'hF, 4'hD, 4'h0, 4'h5, 4'h7, 4'hA, 4'h4, 4'h9, 4'h2, 4'h3, 4'hE, 4'h6, 4'hB, 4'h8, 4'hC}
  };

  // results still owed by the block, oldest first
  logic [63:0] pending_blocks [$];
  int unsigned bad_blocks;
  logic [63:0] want_block;

  // round function: nibble substitution, then rotate left by 11
  function automatic logic [31:0] mix_half(logic [31:0] x);
    logic [31:0] y;
    for (int r = 0; r < 8; r++) begin
      y[28-4*r +: 4] = sub_table[r][x[28-4*r +: 4]];
    end
    return {y[20:0], y[31:21]};
  endfunction

  // 32 feistel rounds; encryption runs the key forwards for 24 rounds,
  // decryption for 8, the rest backwards; halves come out swapped
  function automatic logic [63:0] gost_crypt(logic [63:0] blk, bit decrypt);
    logic [31:0] n1;
    logic [31:0] n2;
    int unsigned k;
    bit          fwd;
    n1 = blk[31:0];
    n2 = blk[63:32];
    for (int r = 0; r < 32; r++) begin
      fwd = decrypt ? (r < 8) : (r < 24);
      k = fwd ? (r % 8) : (7 - r % 8);
      if (r % 2 == 0) begin
        n2 ^= mix_half(n1 + key_word[k]);
      end else begin
        n1 ^= mix_half(n2 + key_word[k]);
      end
    end
    return {n1, n2};
  endfunction

  // result of one request; counter requests step the counter first,
  // restart reloads it from the start value and yields zero
  function automatic logic [63:0] crypt_result(gbc_pkg::gbc_cmd_e op, logic [63:0] blk);
    logic [32:0] hi_sum;
    case (op)
      gbc_pkg::CMD_ENCRYPT: return gost_crypt(blk, 1'b0);
      gbc_pkg::CMD_DECRYPT: return gost_crypt(blk, 1'b1);
      gbc_pkg::CMD_CTR_XOR: begin
        // end-around carry on the high half
        hi_sum = {1'b0, ctr_value[63:32]} + {1'b0, StepHigh};
        ctr_value[63:32] = hi_sum[31:0] + {31'd0, hi_sum[32]};
        ctr_value[31:0] = ctr_value[31:0] + StepLow;
        return blk ^ gost_crypt(ctr_value, 1'b0);
      end
      default: begin
        ctr_value = iv_value;
        return '0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: compare every accepted result with the oldest one owed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_blocks.size() == 0) begin
        $error("data_out: expected nothing, actual %h", data_out_o);
        bad_blocks++;
      end else begin
        want_block = pending_blocks.pop_front();
        if (data_out_o !== want_block) begin
          $error("data_out: expected %h, actual %h", want_block, data_out_o);
          bad_blocks++;
        end
      end
    end
  end

  // receiver stalls: mostly short bursts, now and then a long one, with
  // quiet stretches of varying length between them
  initial begin : stall_driver
    int unsigned run;
    out_stall_i = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      repeat (run) @(posedge clk_i);
      out_stall_i <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      repeat (run) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // request side helpers
  // ---------------------------------------------------------------------------

  // random block, with a bias towards the extremes and single set bits
  function automatic logic [63:0] rand_block();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // present one request and hold it until taken; the owed result is the
  // typed value where the table gives one, else the predictor's
  task automatic send_request(input gbc_pkg::gbc_cmd_e op, input logic [63:0] blk,
                              output logic [63:0] result,
                              input bit typed = 1'b0, input logic [63:0] typed_value = '0);
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    data_in_i  <= blk;
    do @(posedge clk_i); while (in_stall_o);
    result = crypt_result(op, blk);
    pending_blocks = {pending_blocks, (typed ? typed_value : result)};
  endtask

  // idle gap after a request: usually none or short, sometimes long
  task automatic pause_sender(input bit no_gaps);
    int unsigned gap;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    gap = (no_gaps || roll < 55) ? 0 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off new requests until the block owes nothing
  task automatic drain_results();
    if (pending_blocks.size() != 0) begin
      in_valid_i <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clk_i);
    end
  endtask

  // register write; the enable is left high so back-to-back writes need no
  // toggle, the caller drops it after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx <= gbc_pkg::REG_KEY_67) begin
      key_word[2*idx]   = value[31:0];
      key_word[2*idx+1] = value[63:32];
    end else if (idx == gbc_pkg::REG_IV) begin
      iv_value = value;
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table, run under the reset settings (all keys and start value
  // zero); only restart rows have an obvious result
  // ---------------------------------------------------------------------------
  typedef struct {
    gbc_pkg::gbc_cmd_e op;
    logic [63:0]       blk;
    bit                typed;
    logic [63:0]       result;
  } stim_row_t;

  stim_row_t directed_rows [18] = '{
    '{gbc_pkg::CMD_CTR_XOR, 64'h0000_0000_0000_0000, 1'b0, 64'h0},   // counter from reset
    '{gbc_pkg::CMD_CTR_XOR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{gbc_pkg::CMD_ENCRYPT, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{gbc_pkg::CMD_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{gbc_pkg::CMD_DECRYPT, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{gbc_pkg::CMD_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{gbc_pkg::CMD_ENCRYPT, 64'h0000_0000_0000_0001, 1'b0, 64'h0},   // lowest bit of n1
    '{gbc_pkg::CMD_ENCRYPT, 64'h8000_0000_0000_0000, 1'b0, 64'h0},   // top bit of n2
    '{gbc_pkg::CMD_DECRYPT, 64'h0000_0001_0000_0000, 1'b0, 64'h0},
    '{gbc_pkg::CMD_DECRYPT, 64'h0000_0000_8000_0000, 1'b0, 64'h0},
    '{gbc_pkg::CMD_RESTART, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},   // data ignored, zero out
    '{gbc_pkg::CMD_CTR_XOR, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
    '{gbc_pkg::CMD_CTR_XOR, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
    '{gbc_pkg::CMD_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
    '{gbc_pkg::CMD_DECRYPT, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
    '{gbc_pkg::CMD_RESTART, 64'h0000_0000_0000_0000, 1'b1, 64'h0},
    '{gbc_pkg::CMD_CTR_XOR, 64'hFFFF_FFFF_0000_0000, 1'b0, 64'h0},
    '{gbc_pkg::CMD_CTR_XOR, 64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    logic [63:0] res;
    logic [63:0] reg_value [5];
    int unsigned sent;
    int unsigned burst;
    bit          no_gaps;
    bit          paused;
    in_valid_i  = 1'b0;
    cmd_i       = gbc_pkg::CMD_ENCRYPT;
    data_in_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = gbc_pkg::REG_KEY_01;
    cfg_wdata_i = '0;
    key_word    = '{default: '0};
    iv_value    = '0;
    ctr_value   = '0;
    bad_blocks  = 0;
    paused      = 1'b0;
    rst_ni      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].blk, res,
                   directed_rows[i].typed, directed_rows[i].result);
      pause_sender(1'b0);
    end

    // random phases, each under its own register settings
    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      case (phase)
        0: begin
          // every key bit set, start value all ones: high half carry wraps
          reg_value = '{default: '1};
        end
        1: begin
          // high half lands exactly on 2^32 and wraps to one, low half wraps
          foreach (reg_value[i]) reg_value[i] = {$urandom(), $urandom()};
          reg_value[gbc_pkg::REG_IV] = {32'hFEFE_FEFC, 32'hFEFE_FEFF};
        end
        2: begin
          // zero key; high half reaches all ones without a carry
          reg_value = '{default: '0};
          reg_value[gbc_pkg::REG_IV] = {32'hFEFE_FEFB, 32'hFFFF_FFFF};
        end
        default: begin
          foreach (reg_value[i]) reg_value[i] = rand_block();
        end
      endcase
      for (int i = 0; i <= gbc_pkg::REG_IV; i++) begin
        // later phases leave some registers as they were
        if (phase < 3 || $urandom_range(0, 3) != 0) write_reg(3'(i), reg_value[i]);
      end
      // indexes past the last register must be ignored
      if (phase == 1 || phase == 5) begin
        for (int i = int'(gbc_pkg::REG_IV) + 1; i < 8; i++) write_reg(3'(i), rand_block());
      end
      cfg_we_i <= 1'b0;

      no_gaps = (phase % 3 == 2);
      sent = 0;
      while (sent < PhaseItems) begin
        // one pause mid-run until the pipeline is empty
        if (phase == 3 && sent >= PhaseItems / 2 && !paused) begin
          drain_results();
          paused = 1'b1;
        end
        case ($urandom_range(0, 2))
          0: begin
            // round trip: encrypt, then decrypt what came out
            send_request(gbc_pkg::CMD_ENCRYPT, rand_block(), res);
            pause_sender(no_gaps);
            send_request(gbc_pkg::CMD_DECRYPT, res, res);
            pause_sender(no_gaps);
            sent += 2;
          end
          1: begin
            // keystream run, sometimes from a fresh restart
            if ($urandom_range(0, 2) == 0) begin
              send_request(gbc_pkg::CMD_RESTART, rand_block(), res);
              pause_sender(no_gaps);
              sent++;
            end
            burst = $urandom_range(1, 8);
            repeat (burst) begin
              send_request(gbc_pkg::CMD_CTR_XOR, rand_block(), res);
              pause_sender(no_gaps);
            end
            sent += burst;
          end
          default: begin
            send_request(gbc_pkg::gbc_cmd_e'($urandom_range(0, 3)), rand_block(), res);
            pause_sender(no_gaps);
            sent++;
          end
        endcase
      end
    end

    drain_results();
    in_valid_i <= 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    if (bad_blocks == 0) begin
      $display("gost_block_cipher_counter_mode: match");
    end else begin
      $display("gost_block_cipher_counter_mode: mismatch");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("gost_block_cipher_counter_mode: mismatch");
    $finish;
  end

endmodule

// ----- gost_block_cipher_counter_mode.f -----
+incdir+design
design/gbc_pkg.sv
design/gbc_round_cell.sv
design/gost_block_cipher_counter_mode.sv
design/gbc_checker.sv
bench/gost_block_cipher_counter_mode_tb.sv
